### rtl/ascs_pkg.sv
`default_nettype none
package ascs_pkg;

    localparam int SAMPLE_W      = 32;
    localparam int SCALE_W       = 48;
    localparam int SCALE_SPLIT   = 24;
    localparam int PLO_W         = SAMPLE_W + SCALE_SPLIT + 1;
    localparam int PHI_W         = SAMPLE_W + SCALE_W - SCALE_SPLIT;
    localparam int SUM_W         = SAMPLE_W + SCALE_W + 1;
    localparam int FMT_W         = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = SCALE_W;
    localparam int FRAC_BITS_DEF = 24;

    localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(64'd16777216);
    localparam logic [SCALE_W-1:0] OFFSET_RESET = '0;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_TYPE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_VALUE = 2'd3;

    typedef enum logic [FMT_W-1:0] {
        FMT_8U  = 3'd0,
        FMT_8S  = 3'd1,
        FMT_16U = 3'd2,
        FMT_16S = 3'd3,
        FMT_32S = 3'd4
    } fmt_t;

    // per-stage load enables of the datapath
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } ascs_ld_t;

    // saturation bounds, unused codes act as 32s
    function automatic logic signed [SAMPLE_W:0] fmt_max(input logic [FMT_W-1:0] f);
        logic signed [SAMPLE_W:0] v;
        case (f)
            FMT_8U:  v = 33'sd255;
            FMT_8S:  v = 33'sd127;
            FMT_16U: v = 33'sd65535;
            FMT_16S: v = 33'sd32767;
            default: v = 33'sd2147483647;
        endcase
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W:0] fmt_min(input logic [FMT_W-1:0] f);
        logic signed [SAMPLE_W:0] v;
        case (f)
            FMT_8U:  v = 33'sd0;
            FMT_8S:  v = -33'sd128;
            FMT_16U: v = 33'sd0;
            FMT_16S: v = -33'sd32768;
            default: v = -33'sd2147483648;
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] fmt_mask(input logic [FMT_W-1:0] f);
        logic [SAMPLE_W-1:0] v;
        case (f)
            FMT_8U, FMT_8S:   v = 32'h0000_00ff;
            FMT_16U, FMT_16S: v = 32'h0000_ffff;
            default:          v = 32'hffff_ffff;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/ascs_datapath.sv
`default_nettype none
module ascs_datapath
    import ascs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire ascs_ld_t                   ld,
    input  wire logic [FMT_W-1:0]           source_type,
    input  wire logic [FMT_W-1:0]           dest_type,
    input  wire logic signed [SCALE_W-1:0]  scale_factor,
    input  wire logic signed [SCALE_W-1:0]  offset_value,
    input  wire logic [SAMPLE_W-1:0]        sample_bits,
    input  wire logic                       frame_end,
    output logic [SAMPLE_W-1:0]             result_bits,
    output logic                            clipped,
    output logic                            frame_end_out
);

    localparam int RND_W = SUM_W - FRAC_BITS;

    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [PLO_W-1:0]    plo_reg, plo_next;
    logic signed [PHI_W-1:0]    phi_reg, phi_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [RND_W-1:0]    rnd_reg, rnd_next;
    logic [SAMPLE_W-1:0]        res_reg, res_next;
    logic                       clip_reg, clip_next;
    logic [4:0]                 last_reg;
    logic                       round_up;
    logic signed [RND_W-1:0]    max_w, min_w;

    // stage 1: sign or zero extend the sample
    always_comb begin
        case (source_type)
            FMT_8U:  x_next = $signed({24'd0, sample_bits[7:0]});
            FMT_8S:  x_next = $signed({{24{sample_bits[7]}}, sample_bits[7:0]});
            FMT_16U: x_next = $signed({16'd0, sample_bits[15:0]});
            FMT_16S: x_next = $signed({{16{sample_bits[15]}}, sample_bits[15:0]});
            default: x_next = $signed(sample_bits);
        endcase
    end

    // stage 2: two partial products, low half of scale taken unsigned
    assign plo_next = x_reg * $signed({1'b0, scale_factor[SCALE_SPLIT-1:0]});
    assign phi_next = x_reg * $signed(scale_factor[SCALE_W-1:SCALE_SPLIT]);

    // stage 3: recombine and add offset
    assign sum_next = (SUM_W'(phi_reg) <<< SCALE_SPLIT) + SUM_W'(plo_reg)
                    + SUM_W'(offset_value);

    // stage 4: round half to even
    assign round_up = sum_reg[FRAC_BITS-1]
                    && ((|sum_reg[FRAC_BITS-2:0]) || sum_reg[FRAC_BITS]);
    assign rnd_next = $signed(sum_reg[SUM_W-1:FRAC_BITS])
                    + $signed({{(RND_W-1){1'b0}}, round_up});

    // stage 5: saturate to destination
    assign max_w = RND_W'(fmt_max(dest_type));
    assign min_w = RND_W'(fmt_min(dest_type));

    always_comb begin
        if (rnd_reg > max_w) begin
            res_next  = max_w[SAMPLE_W-1:0];
            clip_next = 1'b1;
        end else if (rnd_reg < min_w) begin
            res_next  = min_w[SAMPLE_W-1:0];
            clip_next = 1'b1;
        end else begin
            res_next  = rnd_reg[SAMPLE_W-1:0];
            clip_next = 1'b0;
        end
        res_next = res_next & fmt_mask(dest_type);
    end

    always_ff @(posedge aclk) begin
        if (ld.s1) begin
            x_reg       <= x_next;
            last_reg[0] <= frame_end;
        end
        if (ld.s2) begin
            plo_reg     <= plo_next;
            phi_reg     <= phi_next;
            last_reg[1] <= last_reg[0];
        end
        if (ld.s3) begin
            sum_reg     <= sum_next;
            last_reg[2] <= last_reg[1];
        end
        if (ld.s4) begin
            rnd_reg     <= rnd_next;
            last_reg[3] <= last_reg[2];
        end
        if (ld.s5) begin
            res_reg     <= res_next;
            clip_reg    <= clip_next;
            last_reg[4] <= last_reg[3];
        end
    end

    assign result_bits   = res_reg;
    assign clipped       = clip_reg;
    assign frame_end_out = last_reg[4];

endmodule
`default_nettype wire

### rtl/affine_scale_saturate_convert.sv
// pipeline: 5 register stages; an accepted item moves from stage 1 through stage 5, whose occupancy is m_tvalid
// throughput: one item per cycle while m_tready is high, set by the five-stage pipeline with the
//   48-bit scale multiply split into a 32x25 and a 32x24 partial product
// a stalled output holds only the stages behind it; bubbles further back still fill
// reset: synchronous, active low; empties all stages and restores the
//   configuration registers (8u in, 8u out, scale 1.0, offset 0)
`default_nettype none
module affine_scale_saturate_convert
    import ascs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // configuration write port
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
    // input items
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [SAMPLE_W-1:0]     s_tdata,   // [31:0] sample_bits
    input  wire logic                    s_tlast,   // frame_end
    // result items
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [SAMPLE_W-1:0]          m_tdata,   // [31:0] result_bits
    output logic                         m_tuser,   // [0] clipped
    output logic                         m_tlast    // frame_end_out
);

    // configuration registers
    logic [FMT_W-1:0]   src_type_reg;
    logic [FMT_W-1:0]   dst_type_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [SCALE_W-1:0] offset_reg;

    // pipeline occupancy, bit k is stage k+1
    logic [4:0] v_reg;
    logic [4:0] v_next;
    logic [4:0] rdy;
    ascs_ld_t   ld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_type_reg <= FMT_8U;
            dst_type_reg <= FMT_8U;
            scale_reg    <= SCALE_RESET;
            offset_reg   <= OFFSET_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SOURCE_TYPE:  src_type_reg <= cfg_wdata[FMT_W-1:0];
                REG_DEST_TYPE:    dst_type_reg <= cfg_wdata[FMT_W-1:0];
                REG_SCALE_FACTOR: scale_reg    <= cfg_wdata[SCALE_W-1:0];
                REG_OFFSET_VALUE: offset_reg   <= cfg_wdata[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    // a stage can take an item when it is empty or its own item moves on
    assign rdy[4] = !v_reg[4] || m_tready;
    assign rdy[3] = !v_reg[3] || rdy[4];
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];

    assign ld.s1 = rdy[0] && s_tvalid;
    assign ld.s2 = rdy[1] && v_reg[0];
    assign ld.s3 = rdy[2] && v_reg[1];
    assign ld.s4 = rdy[3] && v_reg[2];
    assign ld.s5 = rdy[4] && v_reg[3];

    always_comb begin
        v_next = v_reg;
        if (rdy[0]) v_next[0] = s_tvalid;
        if (rdy[1]) v_next[1] = v_reg[0];
        if (rdy[2]) v_next[2] = v_reg[1];
        if (rdy[3]) v_next[3] = v_reg[2];
        if (rdy[4]) v_next[4] = v_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // extend, multiply, accumulate, round, saturate
    ascs_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .ld            (ld),
        .source_type   (src_type_reg),
        .dest_type     (dst_type_reg),
        .scale_factor  ($signed(scale_reg)),
        .offset_value  ($signed(offset_reg)),
        .sample_bits   (s_tdata),
        .frame_end     (s_tlast),
        .result_bits   (m_tdata),
        .clipped       (m_tuser),
        .frame_end_out (m_tlast)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[4];

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an item stalled in the first stage is not dropped
    a_stage1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[0] && !rdy[1] |=> v_reg[0])
        else $error("stalled item lost in first stage");

    // an item moved into the output stage shows up as a result
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ld.s5 |=> m_tvalid)
        else $error("item loaded into output stage but no result");

    // an empty pipeline always takes an item
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg == 5'd0 |-> s_tready)
        else $error("empty pipeline refuses items");

endmodule
`default_nettype wire

### dv/affine_scale_saturate_convert_tb.sv
`timescale 1ns / 100ps

import ascs_pkg::*;

// one converted sample as it should leave the block
typedef struct packed {
    logic [SAMPLE_W-1:0] result_bits;
    logic                clipped;
    logic                frame_end;
} conv_result_t;

class convert_scoreboard;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic [FRAC-1:0] HALF = FRAC'(1) << (FRAC - 1);

    logic [FMT_W-1:0]          src_code;
    logic [FMT_W-1:0]          dst_code;
    logic signed [SCALE_W-1:0] scale;
    logic signed [SCALE_W-1:0] offset;
    conv_result_t              pending_conversions[$];
    int                        errors;

    function new();
        src_code = FMT_8U;
        dst_code = FMT_8U;
        scale    = SCALE_RESET;
        offset   = OFFSET_RESET;
        errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_SOURCE_TYPE:  src_code = value[FMT_W-1:0];
            REG_DEST_TYPE:    dst_code = value[FMT_W-1:0];
            REG_SCALE_FACTOR: scale    = value;
            default:          offset   = value;
        endcase
    endfunction

    // widen, multiply-add exactly, round half to even, saturate
    function conv_result_t convert_sample(logic [SAMPLE_W-1:0] raw, logic last);
        conv_result_t        r;
        logic signed [95:0]  x;
        logic signed [95:0]  acc;
        logic signed [95:0]  q;
        logic signed [95:0]  lo_lim;
        logic signed [95:0]  hi_lim;
        logic [SAMPLE_W-1:0] mask;
        logic [FRAC-1:0]     rem;
        fmt_t                sf;
        fmt_t                df;
        sf = (src_code > FMT_32S) ? FMT_32S : fmt_t'(src_code);
        df = (dst_code > FMT_32S) ? FMT_32S : fmt_t'(dst_code);
        case (sf)
            FMT_8U:  x = {88'b0, raw[7:0]};
            FMT_8S:  x = {{88{raw[7]}}, raw[7:0]};
            FMT_16U: x = {80'b0, raw[15:0]};
            FMT_16S: x = {{80{raw[15]}}, raw[15:0]};
            default: x = {{64{raw[31]}}, raw};
        endcase
        acc = x * scale + offset;
        q   = acc >>> FRAC;
        rem = acc[FRAC-1:0];
        if (rem > HALF || (rem == HALF && q[0]))
            q = q + 1;
        case (df)
            FMT_8U: begin
                lo_lim = 0;
                hi_lim = 255;
                mask   = 32'h0000_00ff;
            end
            FMT_8S: begin
                lo_lim = -128;
                hi_lim = 127;
                mask   = 32'h0000_00ff;
            end
            FMT_16U: begin
                lo_lim = 0;
                hi_lim = 65535;
                mask   = 32'h0000_ffff;
            end
            FMT_16S: begin
                lo_lim = -32768;
                hi_lim = 32767;
                mask   = 32'h0000_ffff;
            end
            default: begin
                lo_lim = -96'sd2147483648;
                hi_lim = 96'sd2147483647;
                mask   = 32'hffff_ffff;
            end
        endcase
        r.clipped = 1'b0;
        if (q < lo_lim) begin
            q         = lo_lim;
            r.clipped = 1'b1;
        end else if (q > hi_lim) begin
            q         = hi_lim;
            r.clipped = 1'b1;
        end
        r.result_bits = q[SAMPLE_W-1:0] & mask;
        r.frame_end   = last;
        return r;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw, logic last);
        pending_conversions.push_back(convert_sample(raw, last));
    endfunction

    function int pending();
        return pending_conversions.size();
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] bits_out, logic clip_out, logic last_out);
        conv_result_t want;
        if (pending_conversions.size() == 0) begin
            $display("%0t: unexpected result bits %h clipped %0b last %0b",
                     $time, bits_out, clip_out, last_out);
            errors++;
            return;
        end
        want = pending_conversions.pop_front();
        if (want.result_bits !== bits_out) begin
            $display("%0t: result_bits expected %h got %h", $time, want.result_bits, bits_out);
            errors++;
        end
        if (want.clipped !== clip_out) begin
            $display("%0t: clipped expected %0b got %0b", $time, want.clipped, clip_out);
            errors++;
        end
        if (want.frame_end !== last_out) begin
            $display("%0t: frame_end_out expected %0b got %0b", $time, want.frame_end, last_out);
            errors++;
        end
    endfunction
endclass

module affine_scale_saturate_convert_tb;

    localparam int LATENCY     = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 50;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // configuration port, quiet until the first write
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // sample stream in
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata  = '0;   // [31:0] sample_bits
    logic                s_tlast  = 1'b0; // frame_end

    // converted stream out
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;         // [31:0] result_bits
    logic                m_tuser;         // [0] clipped
    logic                m_tlast;         // frame_end_out

    // percentage of cycles in which each side holds back
    int gap_pct   = 0;
    int stall_pct = 0;
    int cycle_count;

    convert_scoreboard sb = new();

    always #6 aclk = ~aclk;

    affine_scale_saturate_convert #(
        .FRAC_BITS (FRAC_BITS_DEF)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // both handshakes are sampled at the edge, before the new drive settles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("affine_scale_saturate_convert_tb: errors");
        $finish;
    end

    // no idling, idle sender, stalling receiver, light idling on both sides
    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 74; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 74; end
            default: begin gap_pct = 12; stall_pct = 12; end
        endcase
    endtask

    // offers one item, with random idle cycles ahead of it
    task automatic send_sample(input logic [SAMPLE_W-1:0] bits, input logic last);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // stop offering and wait for every result still owed
    task automatic drain_pipeline;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // writes all four registers on back-to-back cycles, pipeline empty
    task automatic set_config(input logic [CFG_DATA_W-1:0] src, input logic [CFG_DATA_W-1:0] dst,
                              input logic [CFG_DATA_W-1:0] scl, input logic [CFG_DATA_W-1:0] ofs);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  idx  [4];
        vals = '{src, dst, scl, ofs};
        idx  = '{REG_SOURCE_TYPE, REG_DEST_TYPE, REG_SCALE_FACTOR, REG_OFFSET_VALUE};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // fixed point values: raw 48 bits, moderate, half steps, unity, tiny, extremes
    function automatic logic [CFG_DATA_W-1:0] random_fixed();
        int k;
        k = 0;
        case ($urandom_range(0, 5))
            0: return CFG_DATA_W'({$urandom, $urandom});
            1: return CFG_DATA_W'(signed'($urandom));
            2: begin
                k = $urandom_range(0, 31) - 16;
                return CFG_DATA_W'(k) << (FRAC_BITS_DEF - 1);
            end
            3: return $urandom_range(0, 1) ? 48'h0000_0100_0000 : 48'hffff_ff00_0000;
            4: begin
                k = $urandom_range(0, 2 ** 21) - 2 ** 20;
                return CFG_DATA_W'(k);
            end
            default: return $urandom_range(0, 1) ? 48'h7fff_ffff_ffff : 48'h8000_0000_0000;
        endcase
    endfunction

    // mostly raw words, some format boundaries under random upper bits, some near zero
    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            1: begin
                case ($urandom_range(0, 6))
                    0: r[7:0]  = 8'h7f;
                    1: r[7:0]  = 8'h80;
                    2: r[15:0] = 16'h7fff;
                    3: r[15:0] = 16'h8000;
                    4: r       = 32'h7fff_ffff;
                    5: r       = 32'h8000_0000;
                    default: r[15:0] = 16'h0000;
                endcase
            end
            2: r = SAMPLE_W'($urandom_range(0, 64)) - 32'd32;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_format();
        // now and then an unused code, which should behave as 32s
        if ($urandom_range(0, 9) == 0)
            return CFG_DATA_W'($urandom_range(5, 7));
        return CFG_DATA_W'($urandom_range(FMT_8U, FMT_32S));
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: 8u in and out, unity scale; upper sample bits ignored
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_00ff, 1'b1);
        send_sample(32'hffff_ff80, 1'b0);
        send_sample(32'hffff_ffff, 1'b1);
        drain_pipeline();

        // largest scale with most negative offset, both saturation rails of 32s
        set_config(CFG_DATA_W'(FMT_32S), CFG_DATA_W'(FMT_32S),
                   48'h7fff_ffff_ffff, 48'h8000_0000_0000);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        drain_pipeline();

        // zero scale and zero offset give zero, never clipped
        set_config(CFG_DATA_W'(FMT_16S), CFG_DATA_W'(FMT_8U), '0, '0);
        send_sample(32'h0000_8000, 1'b0);
        send_sample(32'h0000_7fff, 1'b1);
        drain_pipeline();

        // scale one half: exact halves go to the even neighbour
        set_config(CFG_DATA_W'(FMT_8S), CFG_DATA_W'(FMT_8S), 48'h0000_0080_0000, '0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h0000_0003, 1'b0);
        send_sample(32'h0000_00ff, 1'b0);
        send_sample(32'h0000_00fd, 1'b0);
        send_sample(32'h0000_0080, 1'b1);
        drain_pipeline();

        // unused format codes, most negative scale, largest offset
        set_config(48'd7, 48'd5, 48'h8000_0000_0000, 48'h7fff_ffff_ffff);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        drain_pipeline();

        // 16u into 16s with a half offset: tie at the top then clipped
        set_config(CFG_DATA_W'(FMT_16U), CFG_DATA_W'(FMT_16S),
                   48'h0000_0100_0000, 48'h0000_0080_0000);
        send_sample(32'h0000_ffff, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_7ffe, 1'b1);
        drain_pipeline();

        // random settings, idling pattern rotating with each phase
        for (int p = 0; p < PHASES; p++) begin
            set_idle_mode(p % 4);
            set_config(random_format(), random_format(), random_fixed(),
                       ($urandom_range(0, 3) == 0) ? '0 : random_fixed());
            repeat (PHASE_ITEMS)
                send_sample(random_sample(), $urandom_range(0, 7) == 0);
            drain_pipeline();
        end

        // let any stray result show itself
        repeat (4 * LATENCY) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("affine_scale_saturate_convert_tb: clean");
        else
            $display("affine_scale_saturate_convert_tb: errors");
        $finish;
    end

endmodule
